FILE: sv/scst_pkg.sv
//------------------------------------------------------------------------------
// scst_pkg
// Shared types and codes for the shadow call stack tracer: input function
// codes, event kinds, the result record and the sequencer states.
//------------------------------------------------------------------------------
`default_nettype none

package scst_pkg;

    localparam int ADDR_W = 64;

    // Input function codes
    typedef enum logic [1:0] {
        FN_ENTER = 2'd0,
        FN_EXIT  = 2'd1,
        FN_BEGIN = 2'd2,
        FN_END   = 2'd3
    } t_func;

    // Output event kinds
    typedef enum logic [1:0] {
        EV_ENTER       = 2'd0,
        EV_EXIT        = 2'd1,
        EV_CHILD_ENTER = 2'd2,
        EV_CHILD_EXIT  = 2'd3
    } t_event;

    // One result record
    typedef struct packed {
        t_event              kind;
        logic [ADDR_W-1:0]   routine;
        logic [ADDR_W-1:0]   partner;
        logic                last;
    } t_result;

    // Transfer request from the sequencer into the output buffer
    typedef struct packed {
        logic    push;
        t_result data;
    } t_ob_push;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EN_CE,
        ST_EN_ENT,
        ST_EX_TOP,
        ST_EX_CX,
        ST_RB_EN,
        ST_RB_CE,
        ST_RE_EX,
        ST_RE_CX,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: sv/scst_out_buf.sv
//------------------------------------------------------------------------------
// scst_out_buf
// Two-entry result queue between the sequencer and the output channel, so
// the sequencer keeps working while a finished result waits for transfer.
//------------------------------------------------------------------------------
`default_nettype none

module scst_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire scst_pkg::t_ob_push i_push,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output scst_pkg::t_result       o_data
);
    import scst_pkg::*;

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    // Store a pushed result
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wr_ptr] <= i_push.data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push.push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/shadow_call_stack_tracer.sv
//------------------------------------------------------------------------------
// shadow_call_stack_tracer
// Shadow stack of routine addresses in a one-port-read, one-port-write
// synchronous memory; turns routine enter/exit and region begin/end items
// into enter, exit, child-enter and child-exit events.
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+------------------
//   input   | i_func i_routine_address i_call_site      | i_valid & o_ready
//           | i_in_roi                                  |
//   output  | o_event_kind o_routine o_partner o_last    | o_valid & i_ready
//
// Items are taken one at a time. An enter outside the region, and an exit or
// replay on an empty stack, is handled in idle. An enter in the region runs
// through EN_CE and EN_ENT, or to DONE on an empty stack. An exit visits
// EX_TOP per popped entry and EX_CX per child-exit event, then DONE, also
// outside the region where it gives no events; a replay visits a state per
// event, then DONE. Stack reads are registered. Reset is synchronous and
// clears the count and the top pointer, not the memory. A stalled output
// freezes the sequencer once its two-entry queue and holding register fill.
//------------------------------------------------------------------------------
`default_nettype none

module shadow_call_stack_tracer #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [63:0] i_routine_address,
    input  wire logic [63:0] i_call_site,
    input  wire logic        i_in_roi,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_event_kind,
    output logic [63:0]      o_routine,
    output logic [63:0]      o_partner,
    output logic             o_last
);
    import scst_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int BW = $clog2(2 * STACK_DEPTH);

    // Wrap helpers for the circular stack
    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        res = (idx == AW'(STACK_DEPTH - 1)) ? '0 : idx + AW'(1);
        return res;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        res = (idx == '0) ? AW'(STACK_DEPTH - 1) : idx - AW'(1);
        return res;
    endfunction

    function automatic t_result f_res(input t_event kind, input logic [ADDR_W-1:0] routine,
                                      input logic [ADDR_W-1:0] partner);
        t_result res;
        res.kind    = kind;
        res.routine = routine;
        res.partner = partner;
        res.last    = 1'b0;
        return res;
    endfunction

    // Stack memory and its read register
    logic [ADDR_W-1:0] r_stack [STACK_DEPTH];
    logic [ADDR_W-1:0] r_rd_data;

    // Control and working registers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_top, n_top;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_left, n_left;
    logic [ADDR_W-1:0] r_prev, n_prev;
    logic              r_matched, n_matched;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_site;
    logic              r_roi;
    t_result           r_pend;
    logic              r_pend_valid;

    // Combinational controls
    logic              w_accept;
    logic              w_emit;
    t_result           w_emit_res;
    logic              w_fin;
    logic              w_stall;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_wr_en;
    logic [AW-1:0]     w_top_m1;
    logic [AW-1:0]     w_top_m2;
    logic [BW-1:0]     w_base_sum;
    logic [AW-1:0]     w_base;
    logic              w_full;
    logic              w_ob_space;
    t_ob_push          w_ob_push;
    t_result           w_ob_data;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_top_m1 = f_dec(r_top);
    assign w_top_m2 = f_dec(w_top_m1);
    assign w_full   = (r_count == CW'(STACK_DEPTH));

    // Slot of the bottom entry
    assign w_base_sum = BW'(r_top) + BW'(STACK_DEPTH) - BW'(r_count);
    assign w_base     = (w_base_sum >= BW'(STACK_DEPTH)) ?
                        AW'(w_base_sum - BW'(STACK_DEPTH)) : AW'(w_base_sum);

    // Decode the event produced in the current state
    always_comb begin
        w_emit     = 1'b0;
        w_fin      = 1'b0;
        w_emit_res = f_res(EV_ENTER, r_addr, r_site);
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_func'(i_func) == FN_ENTER) && i_in_roi &&
                    (r_count == '0)) begin
                    w_emit     = 1'b1;
                    w_emit_res = f_res(EV_ENTER, i_routine_address, i_call_site);
                end
            end
            ST_EN_CE: begin
                w_emit     = 1'b1;
                w_emit_res = f_res(EV_CHILD_ENTER, r_addr, r_rd_data);
            end
            ST_EN_ENT: begin
                w_emit     = 1'b1;
                w_emit_res = f_res(EV_ENTER, r_addr, r_site);
            end
            ST_EX_TOP: begin
                w_emit     = r_roi;
                w_emit_res = f_res(EV_EXIT, r_rd_data, '0);
            end
            ST_EX_CX: begin
                w_emit     = 1'b1;
                w_emit_res = f_res(EV_CHILD_EXIT, r_prev, r_rd_data);
            end
            ST_RB_EN: begin
                w_emit     = 1'b1;
                w_emit_res = f_res(EV_ENTER, r_rd_data, '0);
            end
            ST_RB_CE: begin
                w_emit     = 1'b1;
                w_emit_res = f_res(EV_CHILD_ENTER, r_rd_data, r_prev);
            end
            ST_RE_EX: begin
                w_emit     = 1'b1;
                w_emit_res = f_res(EV_EXIT, r_rd_data, '0);
            end
            ST_RE_CX: begin
                w_emit     = 1'b1;
                w_emit_res = f_res(EV_CHILD_EXIT, r_prev, r_rd_data);
            end
            ST_DONE: begin
                w_fin = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Hold everything while the held result cannot move on
    assign w_stall = r_pend_valid && (w_emit || w_fin) && !w_ob_space;

    // Next state
    always_comb begin
        n_state = r_state;
        if (!w_stall) begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (t_func'(i_func))
                            FN_ENTER: begin
                                if (i_in_roi) begin
                                    n_state = (r_count != '0) ? ST_EN_CE : ST_DONE;
                                end
                            end
                            FN_EXIT:  if (r_count != '0) n_state = ST_EX_TOP;
                            FN_BEGIN: if (r_count != '0) n_state = ST_RB_EN;
                            FN_END:   if (r_count != '0) n_state = ST_RE_EX;
                            default:  n_state = ST_IDLE;
                        endcase
                    end
                end
                ST_EN_CE:  n_state = ST_EN_ENT;
                ST_EN_ENT: n_state = ST_DONE;
                ST_EX_TOP: begin
                    if (r_count == CW'(1)) begin
                        n_state = ST_DONE;
                    end else if (r_roi) begin
                        n_state = ST_EX_CX;
                    end else if (r_rd_data == r_addr) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_EX_TOP;
                    end
                end
                ST_EX_CX:  n_state = r_matched ? ST_DONE : ST_EX_TOP;
                ST_RB_EN:  n_state = (r_left == CW'(1)) ? ST_DONE : ST_RB_CE;
                ST_RB_CE:  n_state = ST_RB_EN;
                ST_RE_EX:  n_state = (r_left == CW'(1)) ? ST_DONE : ST_RE_CX;
                ST_RE_CX:  n_state = ST_RE_EX;
                ST_DONE:   n_state = ST_IDLE;
                default:   n_state = ST_IDLE;
            endcase
        end
    end

    // Memory accesses and pointer updates
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_top_m1;
        w_wr_en   = 1'b0;
        n_top     = r_top;
        n_count   = r_count;
        n_slot    = r_slot;
        n_left    = r_left;
        n_prev    = r_prev;
        n_matched = r_matched;
        if (!w_stall) begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (t_func'(i_func))
                            FN_ENTER: begin
                                // push always; overwrite the oldest when full
                                w_wr_en = 1'b1;
                                n_top   = f_inc(r_top);
                                n_count = w_full ? r_count : r_count + CW'(1);
                                w_rd_en = i_in_roi && (r_count != '0);
                            end
                            FN_EXIT: begin
                                w_rd_en = (r_count != '0);
                            end
                            FN_BEGIN: begin
                                w_rd_en   = (r_count != '0);
                                w_rd_addr = w_base;
                                n_slot    = w_base;
                                n_left    = r_count;
                            end
                            FN_END: begin
                                w_rd_en = (r_count != '0);
                                n_slot  = w_top_m1;
                                n_left  = r_count;
                            end
                            default: w_rd_en = 1'b0;
                        endcase
                    end
                end
                ST_EX_TOP: begin
                    // pop the top entry and fetch the one below it
                    n_top     = w_top_m1;
                    n_count   = r_count - CW'(1);
                    n_prev    = r_rd_data;
                    n_matched = (r_rd_data == r_addr);
                    w_rd_addr = w_top_m2;
                    w_rd_en   = (r_count != CW'(1)) && (r_roi || (r_rd_data != r_addr));
                end
                ST_RB_EN: begin
                    n_prev = r_rd_data;
                    if (r_left != CW'(1)) begin
                        n_left    = r_left - CW'(1);
                        n_slot    = f_inc(r_slot);
                        w_rd_addr = f_inc(r_slot);
                        w_rd_en   = 1'b1;
                    end
                end
                ST_RE_EX: begin
                    n_prev = r_rd_data;
                    if (r_left != CW'(1)) begin
                        n_left    = r_left - CW'(1);
                        n_slot    = f_dec(r_slot);
                        w_rd_addr = f_dec(r_slot);
                        w_rd_en   = 1'b1;
                    end
                end
                default: w_rd_en = 1'b0;
            endcase
        end
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[r_top] <= i_routine_address;
        end
        if (w_rd_en) begin
            r_rd_data <= r_stack[w_rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_top        <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_count <= n_count;
            if (!w_stall) begin
                if (w_emit) begin
                    r_pend_valid <= 1'b1;
                end else if (w_fin) begin
                    r_pend_valid <= 1'b0;
                end
            end
        end
    end

    // Working registers and the held result
    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_left    <= n_left;
        r_prev    <= n_prev;
        r_matched <= n_matched;
        if (w_accept) begin
            r_addr <= i_routine_address;
            r_site <= i_call_site;
            r_roi  <= i_in_roi;
        end
        if (!w_stall && w_emit) begin
            r_pend <= w_emit_res;
        end
    end

    // Release the held result once the next one or the end is known
    always_comb begin
        w_ob_push.push      = !w_stall && r_pend_valid && (w_emit || w_fin);
        w_ob_push.data      = r_pend;
        w_ob_push.data.last = w_fin;
    end

    scst_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ob_push),
        .o_space (w_ob_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_ob_data)
    );

    assign o_event_kind = w_ob_data.kind;
    assign o_routine    = w_ob_data.routine;
    assign o_partner    = w_ob_data.partner;
    assign o_last       = w_ob_data.last;

endmodule

`default_nettype wire

FILE: test/shadow_call_stack_tracer_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// shadow_call_stack_tracer_tb
// Self-checking bench for the shadow call stack tracer. It keeps its own copy
// of the shadow stack and predicts the event stream of every transfer on the
// input channel. Each event on the output channel is compared against the
// oldest prediction. Both channels idle at random, with stretches at full rate.
// Directed tests cover the empty stack, enter and exit inside and outside the
// region, unwinds, misses and a wrapped full stack. Random call/return
// traffic and raw noise follow.
//------------------------------------------------------------------------------
module shadow_call_stack_tracer_tb;
    import scst_pkg::*;

    localparam int DEPTH      = 32;
    localparam int MAX_GAP    = 10;
    localparam int DRAIN_WAIT = 200;
    localparam int REPORT_MAX = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_func       i_func;
    logic [63:0] i_routine_address;
    logic [63:0] i_call_site;
    logic        i_in_roi;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_event_kind;
    logic [63:0] o_routine;
    logic [63:0] o_partner;
    logic        o_last;

    // Shadow copy of the call stack
    logic [63:0] shadow_mem [DEPTH];
    int          shadow_count;
    int          shadow_top;

    // Events still owed by the block, oldest first
    t_result     pending_events [$];

    int          mismatch_count;
    int          items_sent;
    int          events_checked;
    int          deepest;
    bit          no_gaps;
    logic [63:0] addr_pool [8];

    shadow_call_stack_tracer #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_routine_address (i_routine_address),
        .i_call_site       (i_call_site),
        .i_in_roi          (i_in_roi),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_event_kind      (o_event_kind),
        .o_routine         (o_routine),
        .o_partner         (o_partner),
        .o_last            (o_last)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        #40_000_000;
        $display("shadow_call_stack_tracer regression: fail");
        $finish;
    end

    // Entry counted from the bottom of the valid part of the stack
    function automatic logic [63:0] stack_entry(int pos);
        int base;
        base = (shadow_top + DEPTH - shadow_count) % DEPTH;
        return shadow_mem[(base + pos) % DEPTH];
    endfunction

    function automatic void queue_event(t_event kind, logic [63:0] routine,
                                        logic [63:0] partner);
        t_result ev;
        ev.kind    = kind;
        ev.routine = routine;
        ev.partner = partner;
        ev.last    = 1'b0;
        pending_events = {pending_events, ev};
    endfunction

    // Drop the top entry, owing its exit events while in the region
    function automatic void pop_shadow(logic roi);
        logic [63:0] top;
        top = stack_entry(shadow_count - 1);
        shadow_top = (shadow_top + DEPTH - 1) % DEPTH;
        shadow_count--;
        if (roi) begin
            queue_event(EV_EXIT, top, '0);
            if (shadow_count != 0)
                queue_event(EV_CHILD_EXIT, top, stack_entry(shadow_count - 1));
        end
    endfunction

    // Advance the shadow stack by one item and queue the events it causes
    function automatic void predict_events(t_func fn, logic [63:0] addr,
                                           logic [63:0] site, logic roi);
        int      before_n;
        t_result tail;
        before_n = pending_events.size();
        case (fn)
            FN_ENTER: begin
                if (roi) begin
                    if (shadow_count != 0)
                        queue_event(EV_CHILD_ENTER, addr, stack_entry(shadow_count - 1));
                    queue_event(EV_ENTER, addr, site);
                end
                // a full stack overwrites its oldest entry
                shadow_mem[shadow_top] = addr;
                shadow_top = (shadow_top + 1) % DEPTH;
                if (shadow_count < DEPTH)
                    shadow_count++;
            end
            FN_EXIT: begin
                // unwind down to the matching entry, or to empty on a miss
                while (shadow_count != 0 && stack_entry(shadow_count - 1) != addr)
                    pop_shadow(roi);
                if (shadow_count != 0)
                    pop_shadow(roi);
            end
            FN_BEGIN: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (i != 0)
                        queue_event(EV_CHILD_ENTER, stack_entry(i), stack_entry(i - 1));
                    queue_event(EV_ENTER, stack_entry(i), '0);
                end
            end
            default: begin
                for (int i = shadow_count; i > 0; i--) begin
                    queue_event(EV_EXIT, stack_entry(i - 1), '0);
                    if (i > 1)
                        queue_event(EV_CHILD_EXIT, stack_entry(i - 1), stack_entry(i - 2));
                end
            end
        endcase
        // flag the final event of this item
        if (pending_events.size() > before_n) begin
            tail = pending_events[pending_events.size() - 1];
            tail.last = 1'b1;
            pending_events[pending_events.size() - 1] = tail;
        end
        if (shadow_count > deepest)
            deepest = shadow_count;
    endfunction

    // Pool addresses repeat often; extremes and full random values fill the rest
    function automatic logic [63:0] rand_addr();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return addr_pool[$urandom_range(0, 7)];
        else if (sel == 4)
            return '0;
        else if (sel == 5)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(t_func fn, logic [63:0] addr, logic [63:0] site,
                             logic roi);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_func            <= fn;
        i_routine_address <= addr;
        i_call_site       <= site;
        i_in_roi          <= roi;
        predict_events(fn, addr, site, roi);
        items_sent++;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Exit and replays with nothing on the stack give no events
    task automatic test_empty_stack();
        send_item(FN_EXIT, 64'h0000_0000_0000_1000, '0, 1'b1);
        send_item(FN_BEGIN, '0, '0, 1'b1);
        send_item(FN_END, '1, '1, 1'b0);
        send_item(FN_END, '0, '0, 1'b1);
    endtask

    // Enter and exit inside and outside the region, unwinds and misses
    task automatic test_call_return();
        send_item(FN_ENTER, '0, '1, 1'b1);
        send_item(FN_ENTER, '1, '0, 1'b1);
        send_item(FN_ENTER, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_item(FN_BEGIN, 64'h1, 64'h2, 1'b0);
        send_item(FN_END, 64'h3, 64'h4, 1'b1);
        send_item(FN_EXIT, 64'h5555_5555_5555_5555, '0, 1'b1);
        send_item(FN_EXIT, '1, '1, 1'b0);
        send_item(FN_ENTER, addr_pool[0], 64'h10, 1'b1);
        send_item(FN_ENTER, addr_pool[1], 64'h20, 1'b1);
        send_item(FN_ENTER, addr_pool[0], 64'h30, 1'b1);
        send_item(FN_ENTER, addr_pool[2], 64'h40, 1'b1);
        // unwind to the upper copy of a repeated routine
        send_item(FN_EXIT, addr_pool[0], '0, 1'b1);
        send_item(FN_EXIT, addr_pool[1], '0, 1'b0);
        // miss: everything left is popped
        send_item(FN_EXIT, 64'hDEAD_BEEF_0000_0001, '0, 1'b1);
    endtask

    // Push past the depth, replay the wrapped stack, then drain it with a miss
    task automatic test_stack_overflow();
        for (int i = 0; i < DEPTH + 3; i++)
            send_item(FN_ENTER, {$urandom, $urandom}, {$urandom, $urandom}, 1'(i % 2));
        send_item(FN_BEGIN, '0, '0, 1'b0);
        send_item(FN_END, '0, '0, 1'b0);
        send_item(FN_EXIT, 64'hFFFF_0000_FFFF_0000, '0, 1'b1);
    endtask

    // Mostly well-formed call/return traffic with some noise mixed in
    task automatic test_random_calls(int count);
        int   pick;
        logic roi;
        for (int k = 0; k < count; k++) begin
            if (k % 25 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            roi  = ($urandom_range(0, 3) != 0);
            if (pick < 45 || (shadow_count == 0 && pick < 80))
                send_item(FN_ENTER, rand_addr(), {$urandom, $urandom}, roi);
            else if (pick < 70)
                send_item(FN_EXIT, stack_entry(shadow_count - 1), rand_addr(), roi);
            else if (pick < 78)
                send_item(FN_EXIT, stack_entry($urandom_range(0, shadow_count - 1)),
                          rand_addr(), roi);
            else if (pick < 80)
                send_item(FN_EXIT, {$urandom, $urandom}, rand_addr(), roi);
            else if (pick < 85)
                send_item(FN_BEGIN, rand_addr(), rand_addr(), roi);
            else if (pick < 90)
                send_item(FN_END, rand_addr(), rand_addr(), roi);
            else
                send_item(t_func'($urandom_range(0, 3)), rand_addr(), rand_addr(),
                          1'($urandom_range(0, 1)));
        end
    endtask

    // Unstructured items with every field random
    task automatic test_random_noise(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 25 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_item(t_func'($urandom_range(0, 3)), rand_addr(), rand_addr(),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Accept events with random stalls and check each against the prediction
    initial begin : event_sink
        int      stall_left;
        int      n;
        t_result exp_ev;
        i_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected event kind %0d routine %h partner %h last %b",
                                 $time, o_event_kind, o_routine, o_partner, o_last);
                end else begin
                    exp_ev = pending_events.pop_front();
                    events_checked++;
                    if (o_event_kind !== exp_ev.kind || o_routine !== exp_ev.routine ||
                        o_partner !== exp_ev.partner || o_last !== exp_ev.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: expected %s %h %h last %b, got %0d %h %h last %b",
                                     $time, exp_ev.kind.name(), exp_ev.routine,
                                     exp_ev.partner, exp_ev.last, o_event_kind,
                                     o_routine, o_partner, o_last);
                    end
                end
                n = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
                if (n > 0) begin
                    i_ready <= 1'b0;
                    stall_left = n;
                end
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    i_ready <= 1'b1;
            end else if (!i_ready) begin
                i_ready <= 1'b1;
            end
        end
    end

    // Run the tests in turn and report
    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_func            = FN_ENTER;
        i_routine_address = '0;
        i_call_site       = '0;
        i_in_roi          = 1'b0;
        shadow_count      = 0;
        shadow_top        = 0;
        mismatch_count    = 0;
        items_sent        = 0;
        events_checked    = 0;
        deepest           = 0;
        no_gaps           = 1'b0;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_call_return();
        test_stack_overflow();
        test_random_calls(200);
        test_random_noise(50);

        // drain what is still owed, then watch for stray events
        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d input items and %0d checked events, %0d mismatches.",
                 items_sent, events_checked, mismatch_count);
        $display("Shadow stack reached depth %0d of %0d.", deepest, DEPTH);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("shadow_call_stack_tracer regression: pass");
        else
            $display("shadow_call_stack_tracer regression: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/scst_pkg.sv
sv/scst_out_buf.sv
sv/shadow_call_stack_tracer.sv
test/shadow_call_stack_tracer_tb.sv
